### rtl/psd_pkg.sv
// Shared types and codes for the Pruefer sequence tree decoder.
// No dependencies.
package psd_pkg;

    localparam int FIELD_W = 17;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    typedef enum logic [0:0] {
        REQ_LOAD = 1'b0,
        REQ_PULL = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_LOADED = 2'd1,
        ST_EMPTY      = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_NODE_COUNT = 1'b0,
        REG_UNUSED     = 1'b1
    } reg_idx_t;

endpackage

### rtl/prufer_sequence_tree_decoder.sv
// Pruefer sequence tree decoder on sequence, degree and leaf min-heap RAMs. Depends on psd_pkg.
// A load is written while idle and busy stays low. A status-only pull answers in the next cycle.
//   An edge pull pops the smallest leaf with a sift-down, then may push the parent with a sift-up.
//   The first edge pull after loading also builds degrees and the heap.
// Throughput: one item at a time, busy high while the sequencer runs; results cannot be stalled.
// Reset: async active low, comes up empty with n = 2; RAMs are not cleared, the build rewrites them.
module prufer_sequence_tree_decoder #(
    parameter int MAX_NODES = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // item channel
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [psd_pkg::FIELD_W-1:0] seq_node,
    // result channel
    output logic                        result_valid,
    output logic [psd_pkg::FIELD_W-1:0] edge_leaf,
    output logic [psd_pkg::FIELD_W-1:0] edge_parent,
    output logic                        last_edge,
    output logic [1:0]                  status,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psd_pkg::ADDR_W-1:0]  paddr,
    input  logic [psd_pkg::DATA_W-1:0]  pwdata,
    output logic [psd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    // label / count width, heap index width, sequence index width
    localparam int LW = $clog2(MAX_NODES + 1);
    localparam int HW = $clog2(MAX_NODES);
    localparam int SW = $clog2(MAX_NODES - 2);
    localparam int SEQ_DEPTH = MAX_NODES - 2;
    localparam int DEG_DEPTH = MAX_NODES + 1;

    typedef enum logic [20:0] {
        S_IDLE  = 21'd1 << 0,
        S_BINIT = 21'd1 << 1,   // degrees of all nodes to one
        S_BRS   = 21'd1 << 2,   // read sequence entry
        S_BRD   = 21'd1 << 3,   // read its degree
        S_BWR   = 21'd1 << 4,   // write degree plus one
        S_SRD   = 21'd1 << 5,   // scan: read degree
        S_SCK   = 21'd1 << 6,   // scan: append leaf
        S_DISP  = 21'd1 << 7,
        S_P0    = 21'd1 << 8,   // pop: read root
        S_P1    = 21'd1 << 9,   // pop: read last
        S_P2    = 21'd1 << 10,
        S_SDL   = 21'd1 << 11,  // sift-down: left child
        S_SDR   = 21'd1 << 12,  // sift-down: right child
        S_SDC   = 21'd1 << 13,  // sift-down: compare
        S_SDW   = 21'd1 << 14,  // sift-down: final write
        S_PA0   = 21'd1 << 15,  // read parent from sequence
        S_PA1   = 21'd1 << 16,  // read parent degree
        S_PA2   = 21'd1 << 17,  // decrement, maybe push
        S_PUCK  = 21'd1 << 18,  // sift-up: read heap parent
        S_PURD  = 21'd1 << 19,  // sift-up: compare
        S_PUW   = 21'd1 << 20   // sift-up: final write
    } state_t;

    typedef enum logic [1:0] {
        M_NORMAL = 2'd0,
        M_FIN1   = 2'd1,
        M_FIN2   = 2'd2
    } mode_t;

    // memories
    logic [LW-1:0] seq_mem  [SEQ_DEPTH];
    logic [LW-1:0] deg_mem  [DEG_DEPTH];
    logic [LW-1:0] heap_mem [MAX_NODES];

    logic          seq_we, deg_we, heap_we;
    logic [SW-1:0] seq_waddr, seq_raddr;
    logic [LW-1:0] deg_waddr, deg_raddr;
    logic [HW-1:0] heap_waddr, heap_raddr;
    logic [LW-1:0] seq_wdata, deg_wdata, heap_wdata;
    logic [LW-1:0] seq_rd, deg_rd, heap_rd;

    always_ff @(posedge clk)
    begin
        if (seq_we)
        begin
            seq_mem[seq_waddr] <= seq_wdata;
        end
        seq_rd <= seq_mem[seq_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_rd <= deg_mem[deg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rd <= heap_mem[heap_raddr];
    end

    // control and datapath registers
    state_t        state_reg, state_next;
    mode_t         mode_reg, mode_next;
    logic [LW-1:0] node_count_reg, node_count_next;
    logic [LW-1:0] loaded_reg, loaded_next;
    logic [LW-1:0] emitted_reg, emitted_next;
    logic [LW-1:0] size_reg, size_next;
    logic          built_reg, built_next;
    logic          done_reg, done_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [HW-1:0] pos_reg, pos_next;
    logic [LW-1:0] lab_reg, lab_next;
    logic [LW-1:0] top_reg, top_next;
    logic [LW-1:0] last_reg, last_next;
    logic [LW-1:0] left_reg, left_next;
    logic [LW-1:0] leaf_reg, leaf_next;

    logic          rv_reg, rv_next;
    logic [LW-1:0] out_leaf_reg, out_leaf_next;
    logic [LW-1:0] out_par_reg, out_par_next;
    logic          out_last_reg, out_last_next;
    psd_pkg::status_t out_st_reg, out_st_next;

    logic [LW-1:0]   need;
    logic [LW-1:0]   loaded_eff;
    logic [HW+1:0]   child;
    logic [HW-1:0]   up_pos;
    logic [LW-1:0]   right_min;
    logic            use_right;
    logic [LW-1:0]   deg_dec;
    logic            cfg_wr;
    logic [psd_pkg::FIELD_W-1:0] cfg_val;
    logic [psd_pkg::FIELD_W-1:0] seq_in;

    assign need     = node_count_reg - LW'(2);
    assign child    = {1'b0, pos_reg, 1'b1};
    assign up_pos   = (pos_reg - HW'(1)) >> 1;
    assign deg_dec  = deg_rd - LW'(1);
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[2] == psd_pkg::REG_NODE_COUNT);
    assign cfg_val  = pwdata[psd_pkg::FIELD_W-1:0];
    assign seq_in   = seq_node;
    assign loaded_eff = done_reg ? '0 : loaded_reg;

    // right child wins only if present and strictly smaller
    assign use_right = ((child + (HW+2)'(1)) < (HW+2)'(size_reg)) && (heap_rd < left_reg);
    assign right_min = use_right ? heap_rd : left_reg;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        node_count_next = node_count_reg;
        loaded_next     = loaded_reg;
        emitted_next    = emitted_reg;
        size_next       = size_reg;
        built_next      = built_reg;
        done_next       = done_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        lab_next        = lab_reg;
        top_next        = top_reg;
        last_next       = last_reg;
        left_next       = left_reg;
        leaf_next       = leaf_reg;
        rv_next         = 1'b0;
        out_leaf_next   = out_leaf_reg;
        out_par_next    = out_par_reg;
        out_last_next   = out_last_reg;
        out_st_next     = out_st_reg;

        seq_we     = 1'b0;
        seq_waddr  = loaded_eff[SW-1:0];
        seq_wdata  = LW'(seq_in);
        seq_raddr  = cnt_reg[SW-1:0];
        deg_we     = 1'b0;
        deg_waddr  = cnt_reg;
        deg_wdata  = LW'(1);
        deg_raddr  = cnt_reg;
        heap_we    = 1'b0;
        heap_waddr = pos_reg;
        heap_wdata = last_reg;
        heap_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_wr)
                begin
                    if (cfg_val < psd_pkg::FIELD_W'(2))
                    begin
                        node_count_next = LW'(2);
                    end
                    else if ((LW+psd_pkg::FIELD_W)'(cfg_val) > (LW+psd_pkg::FIELD_W)'(MAX_NODES))
                    begin
                        node_count_next = LW'(MAX_NODES);
                    end
                    else
                    begin
                        node_count_next = LW'(cfg_val);
                    end
                    size_next    = '0;
                    loaded_next  = '0;
                    emitted_next = '0;
                    built_next   = 1'b0;
                    done_next    = 1'b0;
                end
                else if (start && req_type == psd_pkg::REQ_LOAD)
                begin
                    if (done_reg)
                    begin
                        size_next    = '0;
                        loaded_next  = '0;
                        emitted_next = '0;
                        built_next   = 1'b0;
                        done_next    = 1'b0;
                    end
                    if (seq_in != '0
                        && (LW+psd_pkg::FIELD_W)'(seq_in) <= (LW+psd_pkg::FIELD_W)'(node_count_reg)
                        && loaded_eff < need)
                    begin
                        seq_we      = 1'b1;
                        loaded_next = loaded_eff + LW'(1);
                    end
                end
                else if (start)
                begin
                    out_leaf_next = '0;
                    out_par_next  = '0;
                    out_last_next = 1'b0;
                    if (done_reg)
                    begin
                        rv_next     = 1'b1;
                        out_st_next = psd_pkg::ST_EMPTY;
                    end
                    else if (loaded_reg < need)
                    begin
                        rv_next     = 1'b1;
                        out_st_next = psd_pkg::ST_NOT_LOADED;
                    end
                    else if (!built_reg)
                    begin
                        cnt_next   = LW'(1);
                        size_next  = '0;
                        state_next = S_BINIT;
                    end
                    else
                    begin
                        state_next = S_DISP;
                    end
                end
            end

            S_BINIT:
            begin
                deg_we = 1'b1;
                if (cnt_reg == node_count_reg)
                begin
                    if (loaded_reg == '0)
                    begin
                        cnt_next   = LW'(1);
                        state_next = S_SRD;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = S_BRS;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + LW'(1);
                end
            end

            S_BRS:
            begin
                state_next = S_BRD;
            end

            S_BRD:
            begin
                lab_next   = seq_rd;
                deg_raddr  = seq_rd;
                state_next = S_BWR;
            end

            S_BWR:
            begin
                deg_we    = 1'b1;
                deg_waddr = lab_reg;
                deg_wdata = deg_rd + LW'(1);
                if (cnt_reg + LW'(1) == loaded_reg)
                begin
                    cnt_next   = LW'(1);
                    state_next = S_SRD;
                end
                else
                begin
                    cnt_next   = cnt_reg + LW'(1);
                    state_next = S_BRS;
                end
            end

            S_SRD:
            begin
                state_next = S_SCK;
            end

            S_SCK:
            begin
                // ascending labels: appending keeps the heap order
                if (deg_rd == LW'(1))
                begin
                    heap_we    = 1'b1;
                    heap_waddr = size_reg[HW-1:0];
                    heap_wdata = cnt_reg;
                    size_next  = size_reg + LW'(1);
                end
                if (cnt_reg == node_count_reg)
                begin
                    built_next = 1'b1;
                    state_next = S_DISP;
                end
                else
                begin
                    cnt_next   = cnt_reg + LW'(1);
                    state_next = S_SRD;
                end
            end

            S_DISP:
            begin
                out_leaf_next = '0;
                out_par_next  = '0;
                out_last_next = 1'b0;
                if (emitted_reg < need)
                begin
                    if (size_reg == '0)
                    begin
                        rv_next     = 1'b1;
                        out_st_next = psd_pkg::ST_EMPTY;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        mode_next  = M_NORMAL;
                        state_next = S_P0;
                    end
                end
                else if (size_reg < LW'(2))
                begin
                    rv_next     = 1'b1;
                    out_st_next = psd_pkg::ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mode_next  = M_FIN1;
                    state_next = S_P0;
                end
            end

            S_P0:
            begin
                heap_raddr = '0;
                state_next = S_P1;
            end

            S_P1:
            begin
                top_next   = heap_rd;
                heap_raddr = HW'(size_reg - LW'(1));
                size_next  = size_reg - LW'(1);
                state_next = S_P2;
            end

            S_P2:
            begin
                last_next  = heap_rd;
                pos_next   = '0;
                state_next = S_SDL;
            end

            S_SDL:
            begin
                heap_raddr = child[HW-1:0];
                if (child >= (HW+2)'(size_reg))
                begin
                    state_next = S_SDW;
                end
                else
                begin
                    state_next = S_SDR;
                end
            end

            S_SDR:
            begin
                left_next  = heap_rd;
                heap_raddr = HW'(child + (HW+2)'(1));
                state_next = S_SDC;
            end

            S_SDC:
            begin
                if (right_min >= last_reg)
                begin
                    state_next = S_SDW;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_wdata = right_min;
                    pos_next   = use_right ? HW'(child + (HW+2)'(1)) : child[HW-1:0];
                    state_next = S_SDL;
                end
            end

            S_SDW:
            begin
                heap_we    = 1'b1;
                heap_wdata = last_reg;
                case (mode_reg)
                    M_FIN1:
                    begin
                        leaf_next  = top_reg;
                        mode_next  = M_FIN2;
                        state_next = S_P0;
                    end
                    M_FIN2:
                    begin
                        rv_next       = 1'b1;
                        out_leaf_next = leaf_reg;
                        out_par_next  = top_reg;
                        out_last_next = 1'b1;
                        out_st_next   = psd_pkg::ST_OK;
                        size_next     = '0;
                        loaded_next   = '0;
                        emitted_next  = '0;
                        built_next    = 1'b0;
                        done_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                    default:
                    begin
                        leaf_next  = top_reg;
                        state_next = S_PA0;
                    end
                endcase
            end

            S_PA0:
            begin
                seq_raddr  = emitted_reg[SW-1:0];
                state_next = S_PA1;
            end

            S_PA1:
            begin
                lab_next   = seq_rd;
                deg_raddr  = seq_rd;
                state_next = S_PA2;
            end

            S_PA2:
            begin
                // the leaf's own degree is never read again, so it is left alone
                deg_we    = 1'b1;
                deg_waddr = lab_reg;
                deg_wdata = deg_dec;
                if (deg_dec == LW'(1))
                begin
                    pos_next   = size_reg[HW-1:0];
                    size_next  = size_reg + LW'(1);
                    state_next = S_PUCK;
                end
                else
                begin
                    rv_next       = 1'b1;
                    out_leaf_next = leaf_reg;
                    out_par_next  = lab_reg;
                    out_last_next = 1'b0;
                    out_st_next   = psd_pkg::ST_OK;
                    emitted_next  = emitted_reg + LW'(1);
                    state_next    = S_IDLE;
                end
            end

            S_PUCK:
            begin
                heap_raddr = up_pos;
                if (pos_reg == '0)
                begin
                    state_next = S_PUW;
                end
                else
                begin
                    state_next = S_PURD;
                end
            end

            S_PURD:
            begin
                if (heap_rd <= lab_reg)
                begin
                    state_next = S_PUW;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rd;
                    pos_next   = up_pos;
                    state_next = S_PUCK;
                end
            end

            S_PUW:
            begin
                heap_we       = 1'b1;
                heap_wdata    = lab_reg;
                rv_next       = 1'b1;
                out_leaf_next = leaf_reg;
                out_par_next  = lab_reg;
                out_last_next = 1'b0;
                out_st_next   = psd_pkg::ST_OK;
                emitted_next  = emitted_reg + LW'(1);
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_NORMAL;
            node_count_reg <= LW'(2);
            loaded_reg     <= '0;
            emitted_reg    <= '0;
            size_reg       <= '0;
            built_reg      <= 1'b0;
            done_reg       <= 1'b0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            node_count_reg <= node_count_next;
            loaded_reg     <= loaded_next;
            emitted_reg    <= emitted_next;
            size_reg       <= size_next;
            built_reg      <= built_next;
            done_reg       <= done_next;
            rv_reg         <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        pos_reg      <= pos_next;
        lab_reg      <= lab_next;
        top_reg      <= top_next;
        last_reg     <= last_next;
        left_reg     <= left_next;
        leaf_reg     <= leaf_next;
        out_leaf_reg <= out_leaf_next;
        out_par_reg  <= out_par_next;
        out_last_reg <= out_last_next;
        out_st_reg   <= out_st_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign edge_leaf    = psd_pkg::FIELD_W'(out_leaf_reg);
    assign edge_parent  = psd_pkg::FIELD_W'(out_par_reg);
    assign last_edge    = out_last_reg;
    assign status       = out_st_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == psd_pkg::REG_NODE_COUNT)
                          ? psd_pkg::DATA_W'(node_count_reg) : '0;

    // heap never holds more leaves than there are nodes
    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= node_count_reg)
        else $error("leaf heap larger than node count");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= need)
        else $error("more entries loaded than the sequence holds");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= loaded_reg)
        else $error("more edges than loaded entries");

    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_edge |-> status == psd_pkg::ST_OK && done_reg)
        else $error("final edge without ok status or done flag");

    a_build_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(built_reg) |-> loaded_reg == need)
        else $error("tables built from a partial sequence");

endmodule
